// ===== design/bmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bmbd_pkg
// Types and constants shared by the banked memory bus decoder modules.
// ----------------------------------------------------------------------------
package bmbd_pkg;

   localparam int QueueDepth = 2;

   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_BREAK = 3'd2,
      OP_KEYROW = 3'd3,
      OP_TAPE  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      TGT_NONE  = 3'd0,
      TGT_RAM   = 3'd1,
      TGT_BASIC = 3'd2,
      TGT_PRN   = 3'd3,
      TGT_MON   = 3'd4,
      TGT_PIA   = 3'd5,
      TGT_IO    = 3'd6
   } tgt_type;

   typedef enum logic [1:0] {
      RMT_NONE = 2'd0,
      RMT_OFF  = 2'd1,
      RMT_ON   = 2'd2
   } rmt_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        tape_level;
      logic [31:0] now_usec;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [2:0]  target;
      logic [15:0] mem_address;
      logic        mem_write;
      logic        color_we;
      logic [9:0]  color_index;
      logic [7:0]  color_value;
      logic [1:0]  remote_cmd;
      logic        mic_level;
      logic [4:0]  sound_level;
      logic        nmi_pulse;
      logic [3:0]  kbd_column;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
      logic        lvl;
      logic [31:0] now;
      logic        io_ee;
      logic        e8_win;
      logic        color_hit;
   } cls_type;

   localparam logic [15:0] IO_EE_BASE = 16'hee00;
   localparam logic [15:0] IO_E8_BASE = 16'he800;
   localparam logic [15:0] BASIC_BASE = 16'hb000;
   localparam logic [15:0] PRN_BASE   = 16'he000;
   localparam logic [15:0] MON_BASE   = 16'hf000;
   localparam logic [15:0] COLOR_LO   = 16'h0100;
   localparam logic [15:0] COLOR_HI   = 16'h0400;
   localparam logic [31:0] BIT0_W     = 32'd417;
   localparam logic [31:0] BIT0_TOL   = 32'd42;
   localparam logic [31:0] BIT1_W     = 32'd208;
   localparam logic [31:0] BIT1_TOL   = 32'd21;

endpackage

// ===== design/banked_memory_bus_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// banked_memory_bus_decoder_unit
// Bus decoder: front classifies, queue decouples, back executes.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_payload (req_type)
// rsp      out  rsp_valid/rsp_ready    rsp_payload (rsp_type)
//
// One item per cycle unless results stall; path: queue entry, result register.
// Synchronous active-high reset empties the queue and loads register defaults.
// A stalled result holds the back; the queue then absorbs up to DEPTH items
// before req_ready drops.
// ----------------------------------------------------------------------------
module banked_memory_bus_decoder_unit
   import bmbd_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    q_valid, q_ready;
   cls_type q_item;

   bmbd_front #(.DEPTH(DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .q_valid, .q_ready, .q_item
   );

   bmbd_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .rsp_valid, .rsp_ready, .rsp_payload
   );

endmodule

// ===== design/bmbd_front.sv =====
// ----------------------------------------------------------------------------
// bmbd_front
// Accepts items, classifies address windows and feeds the item queue.
// ----------------------------------------------------------------------------
module bmbd_front
   import bmbd_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    q_valid,
   input  logic    q_ready,
   output cls_type q_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cls_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   cls_type         cls;
   logic            push, pop;

   always_comb begin
      cls.op        = req_payload.operation;
      cls.addr      = req_payload.address;
      cls.data      = req_payload.write_data;
      cls.lvl       = req_payload.tape_level;
      cls.now       = req_payload.now_usec;
      cls.io_ee     = (req_payload.address & 16'hfe00) == IO_EE_BASE;
      cls.e8_win    = (req_payload.address & 16'hf800) == IO_E8_BASE;
      cls.color_hit = req_payload.address >= COLOR_LO && req_payload.address < COLOR_HI;
   end

   assign req_ready = cnt_ff != (AW+1)'(DEPTH);
   assign push      = req_valid && req_ready;
   assign q_valid   = cnt_ff != '0;
   assign pop       = q_valid && q_ready;
   assign q_item    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= cls;
      end
   end

endmodule

// ===== design/bmbd_back.sv =====
// ----------------------------------------------------------------------------
// bmbd_back
// Executes classified items against the I/O registers and drives results.
// ----------------------------------------------------------------------------
module bmbd_back
   import bmbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_ready,
   input  cls_type q_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic [7:0]  bank_ff, bank_in, chr_ff, chr_in, back_ff, back_in;
   logic [7:0]  cae_ff, cae_in, mode_ff, mode_in, row_ff, row_in;
   logic        rev_ff, rev_in, mic_ff, mic_in, nmie_ff, nmie_in;
   logic        brk_ff, brk_in, tprev_ff, tprev_in, tbit_ff, tbit_in;
   logic [4:0]  snd_ff, snd_in;
   logic [3:0]  col_ff, col_in;
   logic [31:0] rise_ff, rise_in, width;
   logic        ovalid_ff, ovalid_in, go;
   rsp_type     out_ff, out_in;
   logic [2:0]  mtgt;
   logic [15:0] moff;
   logic        e8;
   op_type      op;

   assign q_ready     = !ovalid_ff || rsp_ready;
   assign go          = q_valid && q_ready;
   assign rsp_valid   = ovalid_ff;
   assign rsp_payload = out_ff;
   assign e8          = q_item.e8_win && !bank_ff[1];
   assign width       = q_item.now - rise_ff;
   assign op          = op_type'(q_item.op);

   always_comb begin
      mtgt = TGT_RAM;
      moff = q_item.addr;
      if (q_item.addr < BASIC_BASE) begin
         mtgt = TGT_RAM;
      end else if (q_item.addr < PRN_BASE) begin
         if (!bank_ff[0]) begin
            mtgt = TGT_BASIC;
            moff = q_item.addr - BASIC_BASE;
         end
      end else if (q_item.addr < MON_BASE) begin
         if (!bank_ff[1]) begin
            mtgt = TGT_PRN;
            moff = q_item.addr - PRN_BASE;
         end
      end else if (!bank_ff[2]) begin
         mtgt = TGT_MON;
         moff = q_item.addr - MON_BASE;
      end
   end

   always_comb begin
      bank_in = bank_ff; chr_in = chr_ff; back_in = back_ff; cae_in = cae_ff;
      mode_in = mode_ff; row_in = row_ff; rev_in = rev_ff; mic_in = mic_ff;
      nmie_in = nmie_ff; brk_in = brk_ff; tprev_in = tprev_ff; tbit_in = tbit_ff;
      snd_in = snd_ff; col_in = col_ff; rise_in = rise_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      out_in = out_ff;
      if (go) begin
         ovalid_in = 1'b1;
         out_in = '0;
         unique case (op)
            OP_READ: begin
               if (q_item.io_ee) begin
                  out_in.target    = TGT_IO;
                  out_in.read_data = 8'hff;
                  case (q_item.addr)
                     16'hee00: begin
                        out_in.remote_cmd = RMT_OFF;
                        out_in.read_data  = 8'h01;
                     end
                     16'hee20: begin
                        out_in.remote_cmd = RMT_ON;
                        out_in.read_data  = 8'h01;
                     end
                     16'hee80: out_in.read_data = {tbit_ff, 7'd0};
                     16'heec0: out_in.read_data = row_ff;
                     16'hef80: begin
                        out_in.read_data = {brk_ff, 7'd0};
                        brk_in = 1'b0;
                     end
                     16'hefd0: out_in.read_data = bank_ff;
                     default: ;
                  endcase
               end else if (e8) begin
                  if (q_item.addr <= 16'he803) begin
                     out_in.target      = TGT_PIA;
                     out_in.mem_address = {14'd0, q_item.addr[1:0]};
                  end else begin
                     out_in.target = TGT_IO;
                     out_in.read_data = (q_item.addr == 16'he890) ? chr_ff :
                                        (q_item.addr == 16'he891) ? back_ff :
                                        (q_item.addr == 16'he892) ? cae_ff : 8'hff;
                  end
               end else begin
                  out_in.target      = mtgt;
                  out_in.mem_address = moff;
               end
            end
            OP_WRITE: begin
               if (q_item.io_ee) begin
                  out_in.target = TGT_IO;
                  case (q_item.addr)
                     16'hee40: rev_in = q_item.data[7];
                     16'hee80: begin
                        snd_in = q_item.data[5:1];
                        mic_in = ~q_item.data[0];
                     end
                     16'heec0: begin
                        col_in  = q_item.data[3:0];
                        nmie_in = q_item.data[7];
                     end
                     16'hefd0: bank_in = q_item.data;
                     16'hefe0: mode_in = q_item.data;
                     default: ;
                  endcase
               end else if (e8) begin
                  if (q_item.addr <= 16'he803) begin
                     out_in.target      = TGT_PIA;
                     out_in.mem_address = {14'd0, q_item.addr[1:0]};
                     out_in.mem_write   = 1'b1;
                  end else begin
                     out_in.target = TGT_IO;
                     if (q_item.addr == 16'he890) chr_in = q_item.data;
                     else if (q_item.addr == 16'he891) back_in = q_item.data;
                     else if (q_item.addr == 16'he892) cae_in = q_item.data;
                  end
               end else begin
                  if (q_item.color_hit) begin
                     out_in.color_we    = 1'b1;
                     out_in.color_index = 10'(q_item.addr - COLOR_LO);
                     out_in.color_value = chr_ff;
                  end
                  if (mtgt == TGT_RAM) begin
                     out_in.target      = TGT_RAM;
                     out_in.mem_address = moff;
                     out_in.mem_write   = 1'b1;
                  end
               end
            end
            OP_BREAK: begin
               out_in.nmi_pulse = nmie_ff;
               brk_in = 1'b1;
            end
            OP_KEYROW: row_in = q_item.data;
            OP_TAPE: begin
               if (!tprev_ff && q_item.lvl) begin
                  rise_in = q_item.now;
               end else if (tprev_ff && !q_item.lvl) begin
                  if (width > BIT0_W - BIT0_TOL && width < BIT0_W + BIT0_TOL) begin
                     tbit_in = 1'b0;
                  end else if (width > BIT1_W - BIT1_TOL && width < BIT1_W + BIT1_TOL) begin
                     tbit_in = 1'b1;
                  end
               end
               tprev_in = q_item.lvl;
            end
            default: ;
         endcase
         out_in.mic_level   = mic_in;
         out_in.sound_level = snd_in;
         out_in.kbd_column  = col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= '0; chr_ff <= 8'd7; back_ff <= '0; cae_ff <= '0;
         mode_ff <= '0; row_ff <= 8'hff; rev_ff <= 1'b0; mic_ff <= 1'b0;
         nmie_ff <= 1'b0; brk_ff <= 1'b0; tprev_ff <= 1'b0; tbit_ff <= 1'b0;
         snd_ff <= '0; col_ff <= '0; rise_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         bank_ff <= bank_in; chr_ff <= chr_in; back_ff <= back_in; cae_ff <= cae_in;
         mode_ff <= mode_in; row_ff <= row_in; rev_ff <= rev_in; mic_ff <= mic_in;
         nmie_ff <= nmie_in; brk_ff <= brk_in; tprev_ff <= tprev_in;
         tbit_ff <= tbit_in; snd_ff <= snd_in; col_ff <= col_in;
         rise_ff <= rise_in; ovalid_ff <= ovalid_in;
      end
      out_ff <= out_in;
   end

endmodule

// ===== design/bmbd_checker.sv =====
// ----------------------------------------------------------------------------
// bmbd_checker
// Port-level checks on the bus decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bmbd_checker
   import bmbd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_write_only_ram_pia: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mem_write |->
         rsp_payload.target == TGT_RAM || rsp_payload.target == TGT_PIA)
      else $error("write to non-writable target");

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.color_we |->
         rsp_payload.color_index < 10'd768 && rsp_payload.mem_write)
      else $error("bad color write");

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("accepted item produced no result");

endmodule

bind banked_memory_bus_decoder_unit bmbd_checker u_bmbd_checker (
   .clock, .reset, .req_valid, .req_ready, .req_payload,
   .rsp_valid, .rsp_ready, .rsp_payload
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banked memory bus decoder: a directed pass over
// the memory map, I/O registers, break key and tape timing, then random bus
// traffic with bursty requests, random result stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import bmbd_pkg::*;

   class decoder_scoreboard;
      logic [7:0]  bank_q, char_color_q, back_color_q, adapter_q, mode_q;
      logic        reversed_q, mic_q, nmi_en_q, break_q, tape_prev_q, tape_bit_q;
      logic [4:0]  sound_q;
      logic [3:0]  column_q;
      logic [7:0]  key_row_q;
      logic [31:0] rise_q;
      rsp_type     pending[$];
      int          errors;
      int          checked;

      function new();
         bank_q = '0; char_color_q = 8'd7; back_color_q = '0; adapter_q = '0;
         mode_q = '0; reversed_q = 1'b0; mic_q = 1'b0; nmi_en_q = 1'b0;
         break_q = 1'b0; tape_prev_q = 1'b0; tape_bit_q = 1'b0; sound_q = '0;
         column_q = '0; key_row_q = 8'hff; rise_q = '0;
         errors = 0; checked = 0;
      endfunction

      function void map_mem(logic [15:0] a, output logic [2:0] t, output logic [15:0] o);
         if (a < BASIC_BASE) begin
            t = TGT_RAM; o = a;
         end else if (a < PRN_BASE) begin
            if (bank_q[0]) begin t = TGT_RAM; o = a; end
            else begin t = TGT_BASIC; o = a - BASIC_BASE; end
         end else if (a < MON_BASE) begin
            if (bank_q[1]) begin t = TGT_RAM; o = a; end
            else begin t = TGT_PRN; o = a - PRN_BASE; end
         end else begin
            if (bank_q[2]) begin t = TGT_RAM; o = a; end
            else begin t = TGT_MON; o = a - MON_BASE; end
         end
      endfunction

      function void note_request(req_type q);
         rsp_type     r;
         logic        ee, e8;
         logic [15:0] a;
         logic [7:0]  d;
         logic [31:0] w;
         r = '0;
         a = q.address;
         d = q.write_data;
         ee = (a & 16'hfe00) == IO_EE_BASE;
         e8 = (a & 16'hf800) == IO_E8_BASE && !bank_q[1];
         case (q.operation)
            OP_READ: begin
               if (ee) begin
                  r.target = TGT_IO; r.read_data = 8'hff;
                  case (a)
                     16'hee00: begin r.remote_cmd = RMT_OFF; r.read_data = 8'h01; end
                     16'hee20: begin r.remote_cmd = RMT_ON; r.read_data = 8'h01; end
                     16'hee80: r.read_data = {tape_bit_q, 7'd0};
                     16'heec0: r.read_data = key_row_q;
                     16'hef80: begin r.read_data = {break_q, 7'd0}; break_q = 1'b0; end
                     16'hefd0: r.read_data = bank_q;
                     default: ;
                  endcase
               end else if (e8) begin
                  if (a <= 16'he803) begin
                     r.target = TGT_PIA; r.mem_address = {14'd0, a[1:0]};
                  end else begin
                     r.target = TGT_IO;
                     r.read_data = a == 16'he890 ? char_color_q :
                                   a == 16'he891 ? back_color_q :
                                   a == 16'he892 ? adapter_q : 8'hff;
                  end
               end else begin
                  map_mem(a, r.target, r.mem_address);
               end
            end
            OP_WRITE: begin
               if (ee) begin
                  r.target = TGT_IO;
                  case (a)
                     16'hee40: reversed_q = d[7];
                     16'hee80: begin sound_q = d[5:1]; mic_q = ~d[0]; end
                     16'heec0: begin column_q = d[3:0]; nmi_en_q = d[7]; end
                     16'hefd0: bank_q = d;
                     16'hefe0: mode_q = d;
                     default: ;
                  endcase
               end else if (e8) begin
                  if (a <= 16'he803) begin
                     r.target = TGT_PIA; r.mem_address = {14'd0, a[1:0]};
                     r.mem_write = 1'b1;
                  end else begin
                     r.target = TGT_IO;
                     if (a == 16'he890) char_color_q = d;
                     else if (a == 16'he891) back_color_q = d;
                     else if (a == 16'he892) adapter_q = d;
                  end
               end else begin
                  if (a >= COLOR_LO && a < COLOR_HI) begin
                     r.color_we = 1'b1; r.color_index = 10'(a - COLOR_LO);
                     r.color_value = char_color_q;
                  end
                  map_mem(a, r.target, r.mem_address);
                  if (r.target == TGT_RAM) r.mem_write = 1'b1;
                  else begin r.target = TGT_NONE; r.mem_address = '0; end
               end
            end
            OP_BREAK: begin
               r.nmi_pulse = nmi_en_q;
               break_q = 1'b1;
            end
            OP_KEYROW: key_row_q = d;
            OP_TAPE: begin
               if (!tape_prev_q && q.tape_level) rise_q = q.now_usec;
               else if (tape_prev_q && !q.tape_level) begin
                  w = q.now_usec - rise_q;
                  if (w > BIT0_W - BIT0_TOL && w < BIT0_W + BIT0_TOL) tape_bit_q = 1'b0;
                  else if (w > BIT1_W - BIT1_TOL && w < BIT1_W + BIT1_TOL) tape_bit_q = 1'b1;
               end
               tape_prev_q = q.tape_level;
            end
            default: ;
         endcase
         r.mic_level = mic_q;
         r.sound_level = sound_q;
         r.kbd_column = column_q;
         pending.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected item %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got !== e) begin
            errors++;
            $display("%0t mismatch exp %h got %h", $time, e, got);
            if (got.read_data !== e.read_data)
               $display("  read_data exp %h got %h", e.read_data, got.read_data);
            if (got.target !== e.target)
               $display("  target exp %0d got %0d", e.target, got.target);
            if (got.mem_address !== e.mem_address)
               $display("  mem_address exp %h got %h", e.mem_address, got.mem_address);
            if (got.mem_write !== e.mem_write)
               $display("  mem_write exp %b got %b", e.mem_write, got.mem_write);
            if (got.color_we !== e.color_we || got.color_index !== e.color_index ||
                got.color_value !== e.color_value)
               $display("  color exp %b/%h/%h got %b/%h/%h", e.color_we, e.color_index,
                        e.color_value, got.color_we, got.color_index, got.color_value);
            if (got.remote_cmd !== e.remote_cmd)
               $display("  remote_cmd exp %0d got %0d", e.remote_cmd, got.remote_cmd);
            if (got.mic_level !== e.mic_level || got.sound_level !== e.sound_level)
               $display("  mic/sound exp %b/%h got %b/%h", e.mic_level, e.sound_level,
                        got.mic_level, got.sound_level);
            if (got.nmi_pulse !== e.nmi_pulse)
               $display("  nmi_pulse exp %b got %b", e.nmi_pulse, got.nmi_pulse);
            if (got.kbd_column !== e.kbd_column)
               $display("  kbd_column exp %h got %h", e.kbd_column, got.kbd_column);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_payload;

   decoder_scoreboard board = new();
   logic [31:0] tape_clock = 32'd1000;
   bit          stimulus_done = 0;
   bit          hold_off = 0;
   int          sent = 0;

   banked_memory_bus_decoder_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   task automatic send_item(logic [31:0] op, logic [31:0] a, logic [31:0] d,
                            logic [31:0] lvl, logic [31:0] now);
      req_type q;
      q.operation = op[2:0]; q.address = a[15:0]; q.write_data = d[7:0];
      q.tape_level = lvl[0]; q.now_usec = now;
      req_valid <= 1;
      req_payload <= q;
      do @(posedge clock); while (!req_ready);
      board.note_request(q);
      sent++;
   endtask

   task automatic pause_sender(int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   // one tape pulse with a chosen width
   task automatic tape_pulse(logic [31:0] width);
      send_item(OP_TAPE, $urandom, $urandom, 1, tape_clock);
      tape_clock += width;
      send_item(OP_TAPE, $urandom, $urandom, 0, tape_clock);
      tape_clock += $urandom_range(50, 400);
   endtask

   function automatic logic [15:0] pick_address();
      case ($urandom_range(0, 9))
         0: return 16'(16'hee00 | ($urandom_range(0, 7) << 5) | ($urandom_range(0, 1) << 8));
         1: return 16'({14'h3a00, 2'b00} | $urandom_range(0, 3));
         2: return 16'(16'he890 + $urandom_range(0, 3));
         3: return 16'($urandom_range(16'h00f0, 16'h0410));
         4: return 16'($urandom_range(16'hb000, 16'hdfff));
         5: return 16'($urandom_range(16'he000, 16'hefff));
         6: return 16'($urandom_range(16'hf000, 16'hffff));
         7: begin
            case ($urandom_range(0, 6))
               0: return 16'hee00;
               1: return 16'hee20;
               2: return 16'hee40;
               3: return 16'hee80;
               4: return 16'heec0;
               5: return 16'hef80;
               default: return 16'(16'hefd0 + ($urandom_range(0, 1) << 4));
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_item();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40)      send_item(OP_READ, pick_address(), $urandom, $urandom, $urandom);
      else if (k < 75) send_item(OP_WRITE, pick_address(), $urandom, $urandom, $urandom);
      else if (k < 80) send_item(OP_BREAK, $urandom, $urandom, $urandom, $urandom);
      else if (k < 84) send_item(OP_KEYROW, $urandom, $urandom, $urandom, $urandom);
      else if (k < 92) begin
         case ($urandom_range(0, 3))
            0: tape_pulse($urandom_range(370, 464));
            1: tape_pulse($urandom_range(182, 234));
            2: tape_pulse($urandom_range(0, 1000));
            default: tape_pulse($urandom);
         endcase
      end else if (k < 98)
         send_item(OP_TAPE, $urandom, $urandom, $urandom, $urandom);
      else
         send_item($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int burst;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(OP_READ, 16'h0000, 8'h00, 0, 0);
      send_item(OP_WRITE, 16'h0100, 8'hff, 1, 32'hffffffff);
      send_item(OP_WRITE, 16'h03ff, 8'h00, 0, 0);
      send_item(OP_READ, 16'hb000, 0, 0, 0);
      send_item(OP_WRITE, 16'hffff, 8'hff, 0, 0);
      send_item(OP_READ, 16'he803, 0, 0, 0);
      send_item(OP_WRITE, 16'he890, 8'h5a, 0, 0);
      send_item(OP_READ, 16'he890, 0, 0, 0);
      send_item(OP_READ, 16'hee00, 0, 0, 0);
      send_item(OP_READ, 16'hee20, 0, 0, 0);
      send_item(OP_WRITE, 16'hee80, 8'h3e, 0, 0);
      send_item(OP_WRITE, 16'heec0, 8'h8f, 0, 0);
      send_item(OP_BREAK, 0, 0, 0, 0);
      send_item(OP_READ, 16'hef80, 0, 0, 0);
      send_item(OP_READ, 16'hef80, 0, 0, 0);
      send_item(OP_KEYROW, 0, 8'ha5, 0, 0);
      send_item(OP_READ, 16'heec0, 0, 0, 0);
      send_item(OP_WRITE, 16'hefd0, 8'h07, 0, 0);
      send_item(OP_READ, 16'hf000, 0, 0, 0);
      send_item(OP_READ, 16'he800, 0, 0, 0);
      send_item(OP_WRITE, 16'hefd0, 8'h00, 0, 0);
      tape_clock = 32'hffffff00;
      tape_pulse(417);
      send_item(OP_READ, 16'hee80, 0, 0, 0);
      tape_pulse(208);
      send_item(7, 16'hffff, 8'hff, 1, 0);

      while (sent < 1800) begin
         burst = $urandom_range(1, 40);
         repeat (burst) random_item();
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
      end
      req_valid <= 0;
      stimulus_done = 1;
   end

   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_off = 1;
      repeat (200) @(posedge clock);
      hold_off = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_payload);
         if (hold_off) rsp_ready <= 0;
         else if (($time / 64) % 5 == 0) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 2) != 0);
      end
   end

   initial begin
      wait (stimulus_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d items, %0d results checked, %0d failures",
               sent, board.checked, board.errors);
      if (board.errors == 0) $display("PASS banked_memory_bus_decoder_unit");
      else $display("FAIL banked_memory_bus_decoder_unit");
      $finish;
   end

   initial begin
      #200000;
      $display("timeout");
      $display("FAIL banked_memory_bus_decoder_unit");
      $finish;
   end

endmodule
